// ===== src/block_predictor_selector_defines.svh =====
// assertion helpers shared by the predictor selector modules
`ifndef BLOCK_PREDICTOR_SELECTOR_DEFINES_SVH
`define BLOCK_PREDICTOR_SELECTOR_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define BPS_ASSERT_HOLDS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("bps: invariant violated");

// consequent checked in the same cycle as the antecedent
`define BPS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bps: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define BPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bps: next-cycle check failed");

`endif

// ===== src/bps_pkg.sv =====
`timescale 1ns / 1ps
package bps_pkg;

    // block geometry sets the saturation point of the cost sums
    localparam int BLOCK_SIZE = 48;
    localparam int CHANNELS   = 4;

    localparam int NUM_PRED = 10;
    localparam int PIX_W    = 8;
    localparam int COST_W   = 22;
    localparam int IDX_W    = 4;
    localparam int CALC_W   = 13;

    localparam int IN_DATA_W  = 4 * PIX_W;
    localparam int OUT_DATA_W = ((IDX_W + COST_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - IDX_W - COST_W;

    localparam int FULL_BLOCK_COST = 255 * BLOCK_SIZE * BLOCK_SIZE * CHANNELS;
    localparam int SUM_MAX         = (1 << COST_W) - 1;
    localparam logic [COST_W-1:0] COST_CAP = (FULL_BLOCK_COST < SUM_MAX) ?
        COST_W'(FULL_BLOCK_COST) : COST_W'(SUM_MAX);

    // predictor indices as reported on the result channel
    typedef enum logic [IDX_W-1:0] {
        PRED_AVG_LU  = 4'd0,
        PRED_UP      = 4'd1,
        PRED_UPLEFT  = 4'd2,
        PRED_LEFT    = 4'd3,
        PRED_GRAD    = 4'd4,
        PRED_SEMI23  = 4'd5,
        PRED_SEMI5   = 4'd6,
        PRED_SKEW    = 4'd7,
        PRED_AVG_UUL = 4'd8,
        PRED_NONE    = 4'd9
    } pred_t;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef pix_t [NUM_PRED-1:0]       res_vec_t;
    typedef logic [COST_W-1:0]         cost_t;
    typedef cost_t [NUM_PRED-1:0]      cost_vec_t;
    typedef logic signed [CALC_W-1:0]  calc_t;

    // one sample's residuals travelling to the accumulators
    typedef struct packed {
        res_vec_t res;
        logic     last;
    } res_beat_t;

    // predictor candidate in the minimum search
    typedef struct packed {
        pred_t idx;
        cost_t cost;
    } cand_t;

    localparam calc_t PIX_MAX = calc_t'(255);

    // limit a signed intermediate to the pixel range
    function automatic pix_t clamp_pix(calc_t v);
        if (v < 0)
            return '0;
        else if (v > PIX_MAX)
            return '1;
        else
            return v[PIX_W-1:0];
    endfunction

    function automatic pix_t abs_diff(pix_t a, pix_t b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // lower-index candidate goes first; it keeps a tie
    function automatic cand_t min_cand(cand_t lo, cand_t hi);
        return (hi.cost < lo.cost) ? hi : lo;
    endfunction

endpackage

// ===== src/bps_residual.sv =====
`timescale 1ns / 1ps
module bps_residual (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bps_pkg::pix_t     cur_sample,
    input  bps_pkg::pix_t     left_sample,
    input  bps_pkg::pix_t     up_sample,
    input  bps_pkg::pix_t     upleft_sample,
    input  logic              block_last,
    output logic              res_valid,
    input  logic              res_ready,
    output bps_pkg::res_beat_t res_beat
);
    import bps_pkg::*;

    localparam calc_t K1 = calc_t'(1);
    localparam calc_t K3 = calc_t'(3);
    localparam calc_t K5 = calc_t'(5);

    logic          res_valid_reg;
    res_beat_t     res_beat_reg;
    res_beat_t     res_beat_next;
    calc_t         l_s, u_s, ul_s;
    calc_t         grad_v, semi23_v, semi5_v, skew_v;
    logic [PIX_W:0] sum_lu, sum_uul;
    res_vec_t      pred;

    // signed working copies of the neighbours
    assign l_s  = calc_t'(left_sample);
    assign u_s  = calc_t'(up_sample);
    assign ul_s = calc_t'(upleft_sample);

    assign sum_lu  = {1'b0, left_sample} + {1'b0, up_sample};
    assign sum_uul = {1'b0, up_sample} + {1'b0, upleft_sample};

    // gradient style predictors before clamping
    assign grad_v   = l_s + u_s - ul_s;
    assign semi23_v = ((u_s <<< 1) + K3 * l_s - ul_s + K1) >>> 2;
    assign semi5_v  = (K5 * u_s + K5 * l_s - (ul_s <<< 1) + K3) >>> 3;
    assign skew_v   = (K3 * (u_s + l_s) - (ul_s <<< 1)) >>> 2;

    // predictor values
    always_comb begin
        pred               = '0;
        pred[PRED_AVG_LU]  = sum_lu[PIX_W:1];
        pred[PRED_UP]      = up_sample;
        pred[PRED_UPLEFT]  = upleft_sample;
        pred[PRED_LEFT]    = left_sample;
        pred[PRED_GRAD]    = clamp_pix(grad_v);
        pred[PRED_SEMI23]  = clamp_pix(semi23_v);
        pred[PRED_SEMI5]   = clamp_pix(semi5_v);
        pred[PRED_SKEW]    = clamp_pix(skew_v);
        pred[PRED_AVG_UUL] = sum_uul[PIX_W:1];
        pred[PRED_NONE]    = '0;
    end

    // absolute residual per predictor
    always_comb begin
        res_beat_next.last = block_last;
        for (int i = 0; i < NUM_PRED; i++) begin
            res_beat_next.res[i] = abs_diff(cur_sample, pred[i]);
        end
    end

    assign in_ready = !res_valid_reg || res_ready;

    // residual stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (in_ready) begin
            res_valid_reg <= in_valid;
        end
    end

    // residual stage payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_beat_reg <= res_beat_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

endmodule

// ===== src/bps_accum.sv =====
`timescale 1ns / 1ps
`include "block_predictor_selector_defines.svh"
module bps_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    output logic                res_ready,
    input  bps_pkg::res_beat_t  res_beat,
    output logic                snap_valid,
    input  logic                snap_ready,
    output bps_pkg::cost_vec_t  snap_sums
);
    import bps_pkg::*;

    cost_vec_t sums_reg;
    cost_vec_t sums_next;
    cost_vec_t sat_sums;
    cost_vec_t snap_reg;
    logic      snap_valid_reg;
    logic      snap_free;
    logic      consume;
    logic      sums_in_range;
    logic [COST_W:0] wide_sum [NUM_PRED];

    // saturating add of each residual to its sum
    always_comb begin
        for (int i = 0; i < NUM_PRED; i++) begin
            wide_sum[i] = {1'b0, sums_reg[i]} + (COST_W + 1)'(res_beat.res[i]);
            sat_sums[i] = (wide_sum[i] > {1'b0, COST_CAP}) ?
                COST_CAP : wide_sum[i][COST_W-1:0];
        end
    end

    // a block end waits until the snapshot slot is free
    assign snap_free = !snap_valid_reg || snap_ready;
    assign res_ready = !res_beat.last || snap_free;
    assign consume   = res_valid && res_ready;

    always_comb begin
        sums_next = sums_reg;
        if (consume) begin
            sums_next = res_beat.last ? '0 : sat_sums;
        end
    end

    // running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_reg <= '0;
        end else begin
            sums_reg <= sums_next;
        end
    end

    // end-of-block snapshot valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_free) begin
            snap_valid_reg <= consume && res_beat.last;
        end
    end

    // end-of-block snapshot payload
    always_ff @(posedge aclk) begin
        if (consume && res_beat.last) begin
            snap_reg <= sat_sums;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_sums  = snap_reg;

    always_comb begin
        sums_in_range = 1'b1;
        for (int i = 0; i < NUM_PRED; i++) begin
            if (sums_reg[i] > COST_CAP)
                sums_in_range = 1'b0;
        end
    end

    `BPS_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, (consume && res_beat.last), (sums_reg == '0))
    `BPS_ASSERT_HOLDS(a_sums_capped, aclk, aresetn, sums_in_range)
    `BPS_ASSERT_NEXT(a_snap_held, aclk, aresetn, (snap_valid_reg && !snap_ready), (snap_valid_reg && $stable(snap_reg)))

endmodule

// ===== src/bps_argmin.sv =====
`timescale 1ns / 1ps
`include "block_predictor_selector_defines.svh"
module bps_argmin (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               snap_valid,
    output logic                               snap_ready,
    input  bps_pkg::cost_vec_t                 snap_sums,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bps_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import bps_pkg::*;

    localparam int NUM_GRP = 3;

    cand_t               cand [NUM_PRED];
    cand_t [NUM_GRP-1:0] grp_reg;
    cand_t [NUM_GRP-1:0] grp_next;
    cand_t               out_reg;
    cand_t               out_next;
    logic                grp_valid_reg;
    logic                grp_free;
    logic                m_tvalid_reg;
    logic                out_free;

    // tag each sum with its predictor index
    always_comb begin
        for (int i = 0; i < NUM_PRED; i++) begin
            cand[i].idx  = pred_t'(i);
            cand[i].cost = snap_sums[i];
        end
    end

    // first two tree levels: minimum within three groups
    assign grp_next[0] = min_cand(min_cand(cand[0], cand[1]), min_cand(cand[2], cand[3]));
    assign grp_next[1] = min_cand(min_cand(cand[4], cand[5]), min_cand(cand[6], cand[7]));
    assign grp_next[2] = min_cand(cand[8], cand[9]);

    // last two levels across the groups
    assign out_next = min_cand(min_cand(grp_reg[0], grp_reg[1]), grp_reg[2]);

    assign out_free   = !m_tvalid_reg || m_tready;
    assign grp_free   = !grp_valid_reg || out_free;
    assign snap_ready = grp_free;

    // group stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
        end else if (grp_free) begin
            grp_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && grp_free) begin
            grp_reg <= grp_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= grp_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_valid_reg && out_free) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_reg.cost, out_reg.idx};

    `BPS_ASSERT_NEXT(a_min_cost, aclk, aresetn, (grp_valid_reg && out_free), ((out_reg.cost <= $past(grp_reg[0].cost)) && (out_reg.cost <= $past(grp_reg[1].cost)) && (out_reg.cost <= $past(grp_reg[2].cost))))
    `BPS_ASSERT_NEXT(a_grp_held, aclk, aresetn, (grp_valid_reg && !out_free), (grp_valid_reg && $stable(grp_reg)))
    `BPS_ASSERT_SAME(a_tail_group, aclk, aresetn, grp_valid_reg, ((grp_reg[2].idx == PRED_AVG_UUL) || (grp_reg[2].idx == PRED_NONE)))

endmodule

// ===== src/block_predictor_selector.sv =====
`timescale 1ns / 1ps
// result: last sample passes the residual, snapshot, group and output registers
// throughput: one sample per cycle barring m_tready stalls; output is registered
// pipeline: input register, residual register, accumulators, group minimum, output register
// reset: synchronous active-low aresetn clears all valid bits and the ten cost sums
// no clearing pass after reset; the first sample is taken in the cycle after release
module block_predictor_selector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cur_sample [7:0], left_sample [15:8], up_sample [23:16], upleft_sample [31:24]
    input  logic [bps_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // best_filter [3:0], best_cost [25:4], zero [31:26]
    output logic [bps_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import bps_pkg::*;

    logic           in_valid_reg;
    pix_t           cur_reg, left_reg, up_reg, upleft_reg;
    logic           last_reg;
    logic           res_in_ready;
    logic           res_valid;
    logic           res_ready;
    res_beat_t      res_beat;
    logic           snap_valid;
    logic           snap_ready;
    cost_vec_t      snap_sums;

    assign s_tready = !in_valid_reg || res_in_ready;

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cur_reg    <= s_tdata[0*PIX_W +: PIX_W];
            left_reg   <= s_tdata[1*PIX_W +: PIX_W];
            up_reg     <= s_tdata[2*PIX_W +: PIX_W];
            upleft_reg <= s_tdata[3*PIX_W +: PIX_W];
            last_reg   <= s_tlast;
        end
    end

    bps_residual u_residual (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid_reg),
        .in_ready      (res_in_ready),
        .cur_sample    (cur_reg),
        .left_sample   (left_reg),
        .up_sample     (up_reg),
        .upleft_sample (upleft_reg),
        .block_last    (last_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_beat      (res_beat)
    );

    bps_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_beat   (res_beat),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_sums  (snap_sums)
    );

    bps_argmin u_argmin (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap_sums  (snap_sums),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
